FILE: hdl/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg: shared types, constants and the scancode translation table
// Holds the character FIFO depth, the command format passed from the front
// end to the back end, the status codes and the set-1 to ASCII mapping.
// ----------------------------------------------------------------------------
package sc2a_pkg;

    // Character FIFO geometry.
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Command queue between front and back end.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Fixed field widths.
    localparam int CODE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int FILL_W  = 9;
    localparam int STAT_W  = 2;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_ZERO  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_READ   = 2'd1,
        OP_IGNORE = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    localparam logic [CHAR_W-1:0] TOP_ROW [0:9] = '{
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70
    };
    localparam logic [CHAR_W-1:0] HOME_ROW [0:8] = '{
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C
    };
    localparam logic [CHAR_W-1:0] LOW_ROW [0:6] = '{
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D
    };

    localparam logic [CODE_W-1:0] CODE_ZERO_KEY  = 8'h0B;
    localparam logic [CODE_W-1:0] CODE_SPACE     = 8'h39;
    localparam logic [CODE_W-1:0] CODE_ENTER     = 8'h1C;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'h0E;
    localparam logic [CODE_W-1:0] CODE_PERIOD    = 8'h34;
    localparam logic [CODE_W-1:0] CODE_SLASH     = 8'h35;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 7'h0A;
    localparam logic [CHAR_W-1:0] ASCII_PERIOD  = 7'h2E;
    localparam logic [CHAR_W-1:0] ASCII_SLASH   = 7'h2F;

    // Set-1 make code to lower-case ASCII; unmapped codes give zero.
    function automatic logic [CHAR_W-1:0] map_code(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] off_top;
        logic [CODE_W-1:0] off_home;
        logic [CODE_W-1:0] off_low;
        logic [CODE_W-1:0] off_dig;
        logic [CHAR_W-1:0] ch;
        off_top  = code - 8'h10;
        off_home = code - 8'h1E;
        off_low  = code - 8'h2C;
        off_dig  = code - 8'h02;
        ch       = '0;
        if (code inside {[8'h10:8'h19]}) begin
            ch = TOP_ROW[off_top[3:0]];
        end else if (code inside {[8'h1E:8'h26]}) begin
            ch = HOME_ROW[off_home[3:0]];
        end else if (code inside {[8'h2C:8'h32]}) begin
            ch = LOW_ROW[off_low[2:0]];
        end else if (code inside {[8'h02:8'h0A]}) begin
            ch = 7'h31 + off_dig[CHAR_W-1:0];
        end else if (code == CODE_ZERO_KEY) begin
            ch = ASCII_ZERO;
        end else if (code == CODE_SPACE) begin
            ch = ASCII_SPACE;
        end else if (code == CODE_ENTER || code == CODE_BACKSPACE) begin
            ch = ASCII_NEWLINE;
        end else if (code == CODE_PERIOD) begin
            ch = ASCII_PERIOD;
        end else if (code == CODE_SLASH) begin
            ch = ASCII_SLASH;
        end
        return ch;
    endfunction

endpackage

FILE: hdl/scancode_to_ascii_char_fifo.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_char_fifo: keyboard scancode translator and character FIFO
// Translates set-1 make codes to ASCII, queues them, and pops them on read.
// ----------------------------------------------------------------------------
// A push or an ignored code passes through the command queue and the back
// end's result registers; a read also passes through the registered RAM read
// and S_READ. The back end retires one push per cycle while the queue holds
// commands and takes none in S_READ; a two-entry queue raises busy when full.
// Reset (rst_n low, asynchronous) empties the FIFO and the queue; the RAM
// contents are not cleared. Results are not back-pressured: done lasts 1 cycle.
// ----------------------------------------------------------------------------
module scancode_to_ascii_char_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [sc2a_pkg::CODE_W-1:0] scan_code,
    output logic                        done,
    output logic [sc2a_pkg::CHAR_W-1:0] result_char,
    output logic                        char_valid,
    output logic [sc2a_pkg::STAT_W-1:0] status,
    output logic [sc2a_pkg::FILL_W-1:0] fill_level
);
    import sc2a_pkg::*;

    // The front end classifies each item into a command as it is accepted.
    // A zero scancode becomes an ignore command, any other push carries its
    // translated character, and a read carries nothing.
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t front_cmd;
    cmd_t back_cmd;

    sc2a_front u_front (
        .start     (start),
        .func      (func),
        .scan_code (scan_code),
        .q_full    (q_full),
        .busy      (busy),
        .q_push    (q_push),
        .q_cmd     (front_cmd)
    );

    // The queue lets the front keep taking items while the back end waits
    // on a RAM read.
    sc2a_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (front_cmd),
        .pop   (q_pop),
        .dout  (back_cmd),
        .full  (q_full),
        .empty (q_empty)
    );

    // The back end owns the ring pointers, the entry count and the character
    // RAM. A push into a full FIFO is dropped and flagged, a read of an empty
    // FIFO reports the empty status, and every command yields one result.
    sc2a_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (back_cmd),
        .q_pop       (q_pop),
        .done        (done),
        .result_char (result_char),
        .char_valid  (char_valid),
        .status      (status),
        .fill_level  (fill_level)
    );

endmodule

FILE: hdl/sc2a_ram.sv
// ----------------------------------------------------------------------------
// sc2a_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module sc2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/sc2a_front.sv
// ----------------------------------------------------------------------------
// sc2a_front: item intake and classification
// Takes an item when start is high and the queue has room, translates the
// scancode and turns the item into a push, read or ignore command.
// ----------------------------------------------------------------------------
module sc2a_front (
    input  logic                       start,
    input  logic                       func,
    input  logic [sc2a_pkg::CODE_W-1:0] scan_code,
    input  logic                       q_full,
    output logic                       busy,
    output logic                       q_push,
    output sc2a_pkg::cmd_t             q_cmd
);
    import sc2a_pkg::*;

    assign busy   = q_full;
    assign q_push = start && !q_full;

    always_comb
    begin
        q_cmd.ch = '0;
        if (func)
        begin
            q_cmd.op = OP_READ;
        end
        else if (scan_code == '0)
        begin
            q_cmd.op = OP_IGNORE;
        end
        else
        begin
            q_cmd.op = OP_PUSH;
            q_cmd.ch = map_code(scan_code);
        end
    end

endmodule

FILE: hdl/sc2a_cmd_queue.sv
// ----------------------------------------------------------------------------
// sc2a_cmd_queue: short command queue between front and back end
// A small register FIFO of classified commands.
// ----------------------------------------------------------------------------
module sc2a_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sc2a_pkg::cmd_t din,
    input  logic           pop,
    output sc2a_pkg::cmd_t dout,
    output logic           full,
    output logic           empty
);
    import sc2a_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= din;
        end
    end

endmodule

FILE: hdl/sc2a_back.sv
// ----------------------------------------------------------------------------
// sc2a_back: character FIFO execution
// Pops commands, updates the ring pointers and the fill count, drives the
// character RAM and registers each result for one cycle.
// ----------------------------------------------------------------------------
module sc2a_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  sc2a_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic                        done,
    output logic [sc2a_pkg::CHAR_W-1:0] result_char,
    output logic                        char_valid,
    output logic [sc2a_pkg::STAT_W-1:0] status,
    output logic [sc2a_pkg::FILL_W-1:0] fill_level
);
    import sc2a_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } bstate_t;

    bstate_t           state_reg, state_next;
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              valid_reg, valid_next;
    status_t           status_reg, status_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              ram_we;
    logic              ram_re;
    logic [CHAR_W-1:0] ram_rdata;

    sc2a_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (FIFO_DEPTH)
    ) u_char_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (q_cmd.ch),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        state_next  = state_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        char_next   = '0;
        valid_next  = 1'b0;
        status_next = STAT_OK;
        fill_next   = FILL_W'(cnt_reg);
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_cmd.op)
                        OP_PUSH:
                        begin
                            done_next = 1'b1;
                            if (cnt_reg == CNT_W'(FIFO_DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                wptr_next = (wptr_reg == PTR_W'(FIFO_DEPTH - 1)) ?
                                            '0 : wptr_reg + 1'b1;
                                cnt_next  = cnt_reg + 1'b1;
                                fill_next = FILL_W'(cnt_next);
                            end
                        end
                        OP_READ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                rptr_next  = (rptr_reg == PTR_W'(FIFO_DEPTH - 1)) ?
                                             '0 : rptr_reg + 1'b1;
                                cnt_next   = cnt_reg - 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_ZERO;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // RAM data for the pop is available this cycle.
                done_next  = 1'b1;
                char_next  = ram_rdata;
                valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        valid_reg  <= valid_next;
        status_reg <= status_next;
        fill_reg   <= fill_next;
    end

    assign done        = done_reg;
    assign result_char = char_reg;
    assign char_valid  = valid_reg;
    assign status      = status_reg;
    assign fill_level  = fill_reg;

endmodule

FILE: hdl/sc2a_checker.sv
// ----------------------------------------------------------------------------
// sc2a_checker: port-level checks for the scancode FIFO
// Watches the top-level ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module sc2a_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        done,
    input logic [sc2a_pkg::CHAR_W-1:0] result_char,
    input logic                        char_valid,
    input logic [sc2a_pkg::STAT_W-1:0] status,
    input logic [sc2a_pkg::FILL_W-1:0] fill_level
);
    import sc2a_pkg::*;

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && char_valid |-> status == STAT_OK)
        else $error("popped character with a non-ok status");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !char_valid |-> result_char == '0)
        else $error("character shown without a pop");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_EMPTY |-> fill_level == '0)
        else $error("empty status with a nonzero fill level");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_FULL |-> fill_level == FILL_W'(FIFO_DEPTH))
        else $error("full status with the FIFO not full");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result strobe right after reset");

endmodule

bind scancode_to_ascii_char_fifo sc2a_checker u_sc2a_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .done        (done),
    .result_char (result_char),
    .char_valid  (char_valid),
    .status      (status),
    .fill_level  (fill_level)
);
